/* hdl/gqmv_pkg.sv */
`default_nettype none

package gqmv_pkg;

  // Element and product widths
  localparam int unsigned LANES_DEF = 4;
  localparam int unsigned ELEM_W    = 8;
  localparam int unsigned PROD_W    = 2 * ELEM_W;
  localparam int unsigned SCALE_W   = 16;
  localparam int unsigned SC_W      = 2 * SCALE_W;
  localparam int unsigned GSUM_W    = 32;
  localparam int unsigned MUL_W     = 64;
  localparam int unsigned ROW_W     = 48;

  // Saturation bounds of the row value
  localparam logic signed [ROW_W-1:0] ROW_MAX = {1'b0, {(ROW_W-1){1'b1}}};
  localparam logic signed [ROW_W-1:0] ROW_MIN = {1'b1, {(ROW_W-1){1'b0}}};

  // Control that travels with a request through the pipeline
  typedef struct packed {
    logic valid;
    logic g_end;
    logic r_end;
  } tag_t;

endpackage

`default_nettype wire

/* hdl/group_quantized_matvec.sv */
`default_nettype none

// Channel   Dir  tdata                                     tuser      tlast
// s_axis    in   act_0..act_(L-1), wgt_0..wgt_(L-1),       group_end  row_end
//                act_scale, wgt_scale (low bits first)
// m_axis    out  row_value (48, signed Q24)                saturated  -
//
// One request is taken every cycle unless the pipeline holds; the request that
// ends a row passes the lane multiply, group merge, scale multiply and row
// accumulate stages before its result appears. The 32x32 scale multiply and
// the row add-and-clamp each have a stage of their own.
// rst is synchronous and clears the group sum, the row accumulator, the clip
// flag and all stage valid bits.
// While a result waits and m_axis_tready is low, the whole pipeline holds and
// s_axis_tready is low.

module group_quantized_matvec #(
  parameter int unsigned LANES = gqmv_pkg::LANES_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_axis_tvalid,
  output logic                                       s_axis_tready,
  // act_0..act_(LANES-1), wgt_0..wgt_(LANES-1), act_scale, wgt_scale
  input  logic [2*LANES*gqmv_pkg::ELEM_W+2*gqmv_pkg::SCALE_W-1:0] s_axis_tdata,
  // group_end
  input  logic                                       s_axis_tuser,
  input  logic                                       s_axis_tlast,
  output logic                                       m_axis_tvalid,
  input  logic                                       m_axis_tready,
  // row_value
  output logic [gqmv_pkg::ROW_W-1:0]                 m_axis_tdata,
  // saturated
  output logic                                       m_axis_tuser
);
  import gqmv_pkg::*;

  localparam int unsigned WGT_BASE   = LANES * ELEM_W;
  localparam int unsigned SCALE_BASE = 2 * LANES * ELEM_W;

  logic                     adv;
  logic signed [PROD_W-1:0] prod_a [LANES];
  logic [SC_W-1:0]          sc_a;
  logic [SC_W-1:0]          sc_b;
  tag_t                     tag_a;
  tag_t                     tag_b;
  logic [GSUM_W-1:0]        gsum_b;
  logic [SCALE_W-1:0]       act_scale;
  logic [SCALE_W-1:0]       wgt_scale;
  logic signed [ROW_W-1:0]  row_value;

  // Advance everything unless a result waits on a stalled consumer
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign act_scale = s_axis_tdata[SCALE_BASE +: SCALE_W];
  assign wgt_scale = s_axis_tdata[SCALE_BASE+SCALE_W +: SCALE_W];

  // One multiplier per element pair
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    gqmv_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .act  ($signed(s_axis_tdata[i*ELEM_W +: ELEM_W])),
      .wgt  ($signed(s_axis_tdata[WGT_BASE+i*ELEM_W +: ELEM_W])),
      .prod (prod_a[i])
    );
  end

  // Capture request control alongside the lane products
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_a <= '0;
    end else if (adv) begin
      tag_a.valid <= s_axis_tvalid;
      tag_a.g_end <= s_axis_tuser;
      tag_a.r_end <= s_axis_tlast;
    end
  end

  // Combined group scale, kept in step with the group sum
  always_ff @(posedge clk) begin
    if (adv) begin
      sc_a <= act_scale * wgt_scale;
      sc_b <= sc_a;
    end
  end

  gqmv_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .prod     (prod_a),
    .tag_in   (tag_a),
    .gsum_out (gsum_b),
    .tag_out  (tag_b)
  );

  gqmv_rowacc u_rowacc (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .gsum      (gsum_b),
    .scale     (sc_b),
    .tag_in    (tag_b),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .row_value (row_value),
    .saturated (m_axis_tuser)
  );

  assign m_axis_tdata = row_value;

endmodule

`default_nettype wire

/* hdl/gqmv_lane.sv */
`default_nettype none

module gqmv_lane (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [gqmv_pkg::ELEM_W-1:0]   act,
  input  logic signed [gqmv_pkg::ELEM_W-1:0]   wgt,
  output logic signed [gqmv_pkg::PROD_W-1:0]   prod
);
  import gqmv_pkg::*;

  // Multiply one activation by one weight and register the product
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= act * wgt;
    end
  end

endmodule

`default_nettype wire

/* hdl/gqmv_merge.sv */
`default_nettype none

module gqmv_merge #(
  parameter int unsigned LANES = gqmv_pkg::LANES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic signed [gqmv_pkg::PROD_W-1:0]  prod [LANES],
  input  gqmv_pkg::tag_t                      tag_in,
  output logic [gqmv_pkg::GSUM_W-1:0]         gsum_out,
  output gqmv_pkg::tag_t                      tag_out
);
  import gqmv_pkg::*;

  logic [GSUM_W-1:0] group_sum;
  logic [GSUM_W-1:0] lane_sum;
  logic [GSUM_W-1:0] group_sum_next;

  // Add the lane products into the open group (wraps modulo 2^32)
  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_sum = lane_sum + GSUM_W'(prod[i]);
    end
    group_sum_next = group_sum + lane_sum;
  end

  // Hold the group sum; clear it when a group or a row closes
  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum <= '0;
      tag_out   <= '0;
    end else if (en) begin
      tag_out <= tag_in;
      if (tag_in.valid) begin
        if (tag_in.g_end || tag_in.r_end) begin
          group_sum <= '0;
        end else begin
          group_sum <= group_sum_next;
        end
      end
    end
  end

  // Hand the closed group sum on
  always_ff @(posedge clk) begin
    if (en) begin
      gsum_out <= group_sum_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/gqmv_rowacc.sv */
`default_nettype none

module gqmv_rowacc (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic [gqmv_pkg::GSUM_W-1:0]         gsum,
  input  logic [gqmv_pkg::SC_W-1:0]           scale,
  input  gqmv_pkg::tag_t                      tag_in,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [gqmv_pkg::ROW_W-1:0]   row_value,
  output logic                                saturated
);
  import gqmv_pkg::*;

  logic signed [GSUM_W+SC_W:0] full_prod;
  logic signed [MUL_W-1:0]     prod_c;
  tag_t                        tag_c;
  logic signed [ROW_W-1:0]     acc;
  logic                        clip;
  logic signed [MUL_W:0]       acc_sum;
  logic signed [ROW_W-1:0]     acc_next;
  logic                        clip_now;

  // Scale the group sum; the product always fits in 64 bits
  always_comb begin
    full_prod = $signed(gsum) * $signed({1'b0, scale});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_c <= full_prod[MUL_W-1:0];
    end
  end

  // Add the scaled group into the row at a group end and clamp to 48 bits
  always_comb begin
    acc_sum  = (MUL_W+1)'(acc) + (MUL_W+1)'(prod_c);
    acc_next = acc;
    clip_now = 1'b0;
    if (tag_c.g_end) begin
      if (acc_sum > (MUL_W+1)'(ROW_MAX)) begin
        acc_next = ROW_MAX;
        clip_now = 1'b1;
      end else if (acc_sum < (MUL_W+1)'(ROW_MIN)) begin
        acc_next = ROW_MIN;
        clip_now = 1'b1;
      end else begin
        acc_next = acc_sum[ROW_W-1:0];
      end
    end
  end

  // Hold the row state; emit and clear at the end of a row
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_c     <= '0;
      acc       <= '0;
      clip      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // Raise the result flag at a row end; drop it once taken
      if (en && tag_c.valid && tag_c.r_end) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (en) begin
        tag_c <= tag_in;
        if (tag_c.valid) begin
          if (tag_c.r_end) begin
            acc  <= '0;
            clip <= 1'b0;
          end else begin
            acc  <= acc_next;
            clip <= clip | clip_now;
          end
        end
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (en && tag_c.valid && tag_c.r_end) begin
      row_value <= acc_next;
      saturated <= clip | clip_now;
    end
  end

`ifndef ASSERT_OFF
  a_row_clears: assert property (@(posedge clk) disable iff (rst)
    en && tag_c.valid && tag_c.r_end |=> acc == '0 && !clip && out_valid)
    else $error("row state not cleared after a row end");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(acc) && $stable(clip))
    else $error("row accumulator moved during a stall");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(en && tag_c.valid && tag_c.r_end))
    else $error("result appeared without a row end");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !en)
    else $error("pipeline advanced over a waiting result");

  a_mid_group_holds: assert property (@(posedge clk) disable iff (rst)
    en && tag_c.valid && !tag_c.g_end && !tag_c.r_end |=> $stable(acc))
    else $error("accumulator changed inside a group");
`endif

endmodule

`default_nettype wire

/* bench/row_checker.sv */
`timescale 1ns / 1ps

module gqmv_row_checker #(
  parameter int unsigned LANES = gqmv_pkg::LANES_DEF
) (
  input  logic                                                    clk,
  input  logic                                                    rst,
  input  logic                                                    s_axis_tvalid,
  input  logic                                                    s_axis_tready,
  // act_0..act_(LANES-1), wgt_0..wgt_(LANES-1), act_scale, wgt_scale
  input  logic [2*LANES*gqmv_pkg::ELEM_W+2*gqmv_pkg::SCALE_W-1:0] s_axis_tdata,
  // group_end
  input  logic                                                    s_axis_tuser,
  input  logic                                                    s_axis_tlast,
  input  logic                                                    m_axis_tvalid,
  input  logic                                                    m_axis_tready,
  // row_value
  input  logic [gqmv_pkg::ROW_W-1:0]                              m_axis_tdata,
  // saturated
  input  logic                                                    m_axis_tuser,
  output int                                                      pending,
  output int                                                      requests,
  output int                                                      rows,
  output int                                                      clipped_rows,
  output int                                                      mismatches
);

  localparam int unsigned ELEM_W  = gqmv_pkg::ELEM_W;
  localparam int unsigned PROD_W  = gqmv_pkg::PROD_W;
  localparam int unsigned SCALE_W = gqmv_pkg::SCALE_W;
  localparam int unsigned GSUM_W  = gqmv_pkg::GSUM_W;
  localparam int unsigned DATA_W  = 2*LANES*ELEM_W + 2*SCALE_W;
  localparam int unsigned SCL_LSB = 2*LANES*ELEM_W;
  localparam longint      ROW_HI  = gqmv_pkg::ROW_MAX;
  localparam longint      ROW_LO  = gqmv_pkg::ROW_MIN;
  localparam int          PRINT_CAP = 100;

  typedef struct packed {
    logic [gqmv_pkg::ROW_W-1:0] value;
    logic                       clipped;
  } row_result_t;

  row_result_t                 expected_rows[$];
  logic [GSUM_W-1:0]           group_sum_q;
  longint                      row_acc_q;
  logic                        clip_q;
  int                          request_cnt;
  int                          row_cnt;
  int                          clip_cnt;
  int                          error_cnt;

  // Print one line per mismatch (up to a cap) and count every one
  task automatic report(input string what);
    if (error_cnt < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
    error_cnt++;
  endtask

  // Fold one request into the group sum and row value; queue a row on row end
  task automatic predict_request(input logic [DATA_W-1:0] data, input logic g_end,
                                 input logic r_end);
    logic signed [PROD_W-1:0]     prod;
    logic [gqmv_pkg::SC_W-1:0]    scale_prod;
    longint                       gsum;
    longint                       scale;
    longint                       acc;
    row_result_t                  res;
    for (int lane = 0; lane < LANES; lane++) begin
      prod = $signed(data[lane*ELEM_W +: ELEM_W]) *
             $signed(data[(LANES+lane)*ELEM_W +: ELEM_W]);
      group_sum_q = group_sum_q + {{(GSUM_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
    if (g_end) begin
      scale_prod = data[SCL_LSB +: SCALE_W] * data[SCL_LSB+SCALE_W +: SCALE_W];
      gsum = $signed(group_sum_q);
      scale = scale_prod;
      acc = row_acc_q + gsum * scale;
      // Clamp to the 48-bit row range and remember the clip
      if (acc > ROW_HI) begin
        acc = ROW_HI;
        clip_q = 1'b1;
      end else if (acc < ROW_LO) begin
        acc = ROW_LO;
        clip_q = 1'b1;
      end
      row_acc_q = acc;
      group_sum_q = '0;
    end
    // An open partial group is dropped along with the rest on row end
    if (r_end) begin
      res.value = row_acc_q[gqmv_pkg::ROW_W-1:0];
      res.clipped = clip_q;
      expected_rows.push_back(res);
      group_sum_q = '0;
      row_acc_q = 0;
      clip_q = 1'b0;
    end
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    row_result_t want;
    if (rst) begin
      group_sum_q = '0;
      row_acc_q = 0;
      clip_q = 1'b0;
      expected_rows.delete();
      request_cnt = 0;
      row_cnt = 0;
      clip_cnt = 0;
      error_cnt = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        request_cnt++;
        predict_request(s_axis_tdata, s_axis_tuser, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        row_cnt++;
        if (m_axis_tuser) begin
          clip_cnt++;
        end
        if (expected_rows.size() == 0) begin
          report($sformatf("row %0d: result %0d arrived with none expected", row_cnt,
                           $signed(m_axis_tdata)));
        end else begin
          want = expected_rows.pop_front();
          if (m_axis_tdata !== want.value) begin
            report($sformatf("row %0d: row_value %0d, expected %0d", row_cnt,
                             $signed(m_axis_tdata), $signed(want.value)));
          end
          if (m_axis_tuser !== want.clipped) begin
            report($sformatf("row %0d: saturated %b, expected %b", row_cnt,
                             m_axis_tuser, want.clipped));
          end
        end
      end
    end
    pending      <= expected_rows.size();
    requests     <= request_cnt;
    rows         <= row_cnt;
    clipped_rows <= clip_cnt;
    mismatches   <= error_cnt;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LANES     = gqmv_pkg::LANES_DEF;
  localparam int unsigned LANE_BITS = LANES * gqmv_pkg::ELEM_W;
  localparam int unsigned DATA_W    = 2*LANES*gqmv_pkg::ELEM_W + 2*gqmv_pkg::SCALE_W;
  localparam int          GROUP_SIZE      = 32;
  localparam int          RANDOM_REQUESTS = 450;
  localparam int          TAIL_CYCLES     = 16;
  localparam int          CYCLE_LIMIT     = 20000;

  localparam logic [LANE_BITS-1:0] ALL_MIN   = {LANES{8'h80}};
  localparam logic [LANE_BITS-1:0] ALL_MAX   = {LANES{8'h7f}};
  localparam logic [15:0]          SCALE_ONE = 16'h1000;
  localparam logic [15:0]          SCALE_MAX = 16'hffff;

  // Scale selection for a random group
  typedef enum int {
    SCALE_ANY,
    SCALE_NEAR_ONE,
    SCALE_EDGE
  } scale_mode_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              s_axis_tlast = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [gqmv_pkg::ROW_W-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  logic              steady = 1'b0;
  int                sent = 0;
  int                cycle_count = 0;
  int                pending;
  int                requests;
  int                rows;
  int                clipped_rows;
  int                mismatches;

  group_quantized_matvec #(
    .LANES(LANES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  gqmv_row_checker #(
    .LANES(LANES)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .pending      (pending),
    .requests     (requests),
    .rows         (rows),
    .clipped_rows (clipped_rows),
    .mismatches   (mismatches)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d rows still outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stall the result side at random, except during the steady stretch
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 24);
  end

  // Present one request and hold it until taken
  task automatic send_request(input logic [LANE_BITS-1:0] acts, input logic [LANE_BITS-1:0] wgts,
                              input logic [15:0] a_sc, input logic [15:0] w_sc,
                              input logic g_end, input logic r_end);
    if (!steady) begin
      while ($urandom_range(99) < 24) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w_sc, a_sc, wgts, acts};
    s_axis_tuser  <= g_end;
    s_axis_tlast  <= r_end;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent++;
  endtask

  // Hold off new requests until every queued row has come back
  task automatic wait_for_rows();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [LANE_BITS-1:0] rand_lanes();
    logic [LANE_BITS-1:0] v;
    v = $urandom;
    for (int lane = 0; lane < LANES; lane++) begin
      case ($urandom_range(15))
        0: v[lane*8 +: 8] = 8'h80;
        1: v[lane*8 +: 8] = 8'h7f;
        default: ;
      endcase
    end
    return v;
  endfunction

  function automatic logic [15:0] rand_scale(input scale_mode_e mode);
    logic [15:0] v;
    case (mode)
      SCALE_NEAR_ONE: v = 16'($urandom_range(8191));
      SCALE_EDGE:     v = $urandom_range(1) ? SCALE_MAX : 16'h0000;
      default:        v = 16'($urandom);
    endcase
    return v;
  endfunction

  // One row: mostly well-formed groups, sometimes with stray or missing markers
  task automatic random_row();
    int          groups;
    int          len;
    bit          broken;
    scale_mode_e mode;
    logic        g_end;
    logic        r_end;
    broken = ($urandom_range(9) == 0);
    groups = $urandom_range(1, 4);
    for (int g = 0; g < groups; g++) begin
      len = ($urandom_range(9) == 0) ? GROUP_SIZE : $urandom_range(1, 8);
      mode = scale_mode_e'($urandom_range(2));
      for (int i = 0; i < len; i++) begin
        r_end = (g == groups - 1) && (i == len - 1);
        g_end = broken ? ($urandom_range(3) == 0) : (i == len - 1);
        send_request(rand_lanes(), rand_lanes(), rand_scale(mode), rand_scale(mode),
                     g_end, r_end);
      end
    end
  endtask

  initial begin
    int random_start;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners
    send_request(ALL_MAX, ALL_MAX, SCALE_ONE, SCALE_ONE, 1'b1, 1'b1);
    send_request(ALL_MIN, ALL_MIN, SCALE_MAX, SCALE_MAX, 1'b1, 1'b1);
    send_request(ALL_MIN, ALL_MAX, SCALE_MAX, SCALE_MAX, 1'b1, 1'b1);
    send_request(ALL_MIN, ALL_MAX, 16'h0000, 16'h0000, 1'b1, 1'b1);
    send_request(32'h01ff_7f80, 32'h807f_01ff, SCALE_MAX, 16'h0001, 1'b1, 1'b1);
    send_request('0, '0, '0, '0, 1'b1, 1'b1);
    // row end on an open group drops that group
    send_request(rand_lanes(), rand_lanes(), SCALE_ONE, SCALE_ONE, 1'b1, 1'b0);
    send_request(ALL_MAX, ALL_MAX, SCALE_ONE, SCALE_ONE, 1'b0, 1'b1);
    // row end with no group closed at all
    send_request(ALL_MAX, ALL_MIN, SCALE_MAX, SCALE_MAX, 1'b0, 1'b1);
    // several groups in one row; scales on inner beats are ignored
    for (int g = 0; g < 3; g++) begin
      send_request(rand_lanes(), rand_lanes(), SCALE_MAX, SCALE_MAX, 1'b0, 1'b0);
      send_request(rand_lanes(), rand_lanes(), SCALE_ONE + 16'(g), SCALE_ONE, 1'b1, g == 2);
    end
    // clip high, then pull back down within the same row
    send_request(ALL_MIN, ALL_MIN, SCALE_MAX, SCALE_MAX, 1'b1, 1'b0);
    send_request(ALL_MIN, ALL_MAX, 16'h4000, 16'h4000, 1'b1, 1'b1);
    wait_for_rows();

    // Random rows, with one stretch free of stalls on both sides
    random_start = sent;
    while (sent - random_start < RANDOM_REQUESTS) begin
      steady <= (sent - random_start >= 150) && (sent - random_start < 260);
      random_row();
    end
    steady <= 1'b0;

    // Drain and let the pipeline settle
    wait_for_rows();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests giving %0d rows (%0d clipped): corner values, dropped groups,",
             requests, rows, clipped_rows);
    $display("malformed rows and random stalls on both sides with a stall-free stretch.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
